@@ src/sbdp_pkg.sv @@
// Shared types, codes and constants of the bulk-dump message parser.
`default_nettype none

package sbdp_pkg;

    // Stream bytes that frame a message.
    localparam logic [7:0] MSG_START = 8'hF0;
    localparam logic [7:0] MSG_END   = 8'hF7;

    // Byte positions inside a message, F0 being position 0.
    localparam int unsigned POS_W = 15;
    localparam logic [POS_W-1:0] POS_MAX        = 15'h7FFF;
    localparam logic [POS_W-1:0] POS_MAKER      = 15'd1;
    localparam logic [POS_W-1:0] POS_BULK       = 15'd2;
    localparam logic [POS_W-1:0] POS_MODEL      = 15'd3;
    localparam logic [POS_W-1:0] POS_COUNT_HI   = 15'd4;
    localparam logic [POS_W-1:0] POS_COUNT_LO   = 15'd5;
    localparam logic [POS_W-1:0] POS_ADDR_HI    = 15'd6;
    localparam logic [POS_W-1:0] POS_ADDR_MID   = 15'd7;
    localparam logic [POS_W-1:0] POS_ADDR_LO    = 15'd8;
    localparam logic [POS_W-1:0] POS_DATA_START = 15'd9;
    localparam logic [POS_W-1:0] POS_MIN_END    = 15'd10;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_MANUFACTURER_ID    = 2'd0,
        CFG_MODEL_ID           = 2'd1,
        CFG_VOICE_ADDRESS_HIGH = 2'd2,
        CFG_MIN_DATA_BYTES     = 2'd3
    } cfg_idx_t;

    localparam logic [6:0]  RST_MANUFACTURER_ID    = 7'd67;
    localparam logic [6:0]  RST_MODEL_ID           = 7'd0;
    localparam logic [6:0]  RST_VOICE_ADDRESS_HIGH = 7'd0;
    localparam logic [13:0] RST_MIN_DATA_BYTES     = 14'd65;

    // Verdict codes.
    typedef enum logic [3:0] {
        ST_OK           = 4'd0,
        ST_NOT_SYSEX    = 4'd1,
        ST_MANUFACTURER = 4'd2,
        ST_NOT_BULK     = 4'd3,
        ST_MODEL        = 4'd4,
        ST_LENGTH       = 4'd5,
        ST_CHECKSUM     = 4'd6,
        ST_ADDRESS      = 4'd7,
        ST_TOO_SHORT    = 4'd8
    } status_t;

    typedef struct packed {
        logic [6:0]  manufacturer_id;
        logic [6:0]  model_id;
        logic [6:0]  voice_address_high;
        logic [13:0] min_data_bytes;
    } cfg_t;

    typedef struct packed {
        logic        is_verdict;
        logic [6:0]  data_byte;
        logic [13:0] data_index;
        status_t     status;
        logic [20:0] dump_address;
        logic [13:0] data_count;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

@@ src/sysex_bulk_dump_parser_unit.sv @@
// Top level of the bulk-dump system exclusive message parser.
`default_nettype none

// The parser takes one raw MIDI byte per item and accepts a new byte in every
// cycle as long as the output side keeps up, so a steady stream runs at one
// byte per clock. A byte is held in an input register, decoded combinationally
// against the message state once the result register is free, and any result
// lands in that output register, from which it is offered on the output. Each
// accepted byte yields at most one item: a data item (is_verdict low) for every
// data byte inside the announced count, masked to seven bits and tagged with
// its offset, and one verdict item (is_verdict and last high) at each F7 that
// closes a message. Bytes outside a message yield nothing; an F0 there opens
// a message. Data items are passed on before the message is judged, so the
// receiver must drop the data of any message whose verdict status is not zero.
// The four configuration registers are written through cfg_wr_en, cfg_index
// and cfg_wr_data, one register per cycle, and should only be changed while
// the parser is idle.

module sysex_bulk_dump_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [13:0] cfg_wr_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  byte_in,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             is_verdict,
    output logic [6:0]       data_byte,
    output logic [13:0]      data_index,
    output logic [3:0]       status,
    output logic [20:0]      dump_address,
    output logic [13:0]      data_count,
    output logic             last
);

    sbdp_pkg::cfg_t    cfg;
    sbdp_pkg::result_t res;
    sbdp_pkg::result_t out_res;
    logic              held_valid;
    logic [7:0]        held_byte;
    logic              out_free;
    logic              take;
    logic              res_valid;

    // The held byte is decoded once the result register can take its item.
    assign take = held_valid && out_free;

    sbdp_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    sbdp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_in    (byte_in),
        .take       (take),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sbdp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (take),
        .byte_cur  (held_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    sbdp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res       (res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign is_verdict   = out_res.is_verdict;
    assign data_byte    = out_res.data_byte;
    assign data_index   = out_res.data_index;
    assign status       = out_res.status;
    assign dump_address = out_res.dump_address;
    assign data_count   = out_res.data_count;
    assign last         = out_res.last;

endmodule

`default_nettype wire

@@ src/sbdp_cfg.sv @@
// Configuration registers of the bulk-dump message parser.
`default_nettype none

module sbdp_cfg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [13:0]         cfg_wr_data,
    output sbdp_pkg::cfg_t           cfg
);

    sbdp_pkg::cfg_t cfg_reg;
    sbdp_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (sbdp_pkg::cfg_idx_t'(cfg_index))
                sbdp_pkg::CFG_MANUFACTURER_ID:    cfg_next.manufacturer_id    = cfg_wr_data[6:0];
                sbdp_pkg::CFG_MODEL_ID:           cfg_next.model_id           = cfg_wr_data[6:0];
                sbdp_pkg::CFG_VOICE_ADDRESS_HIGH: cfg_next.voice_address_high = cfg_wr_data[6:0];
                sbdp_pkg::CFG_MIN_DATA_BYTES:     cfg_next.min_data_bytes     = cfg_wr_data;
                default:                          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.manufacturer_id    <= sbdp_pkg::RST_MANUFACTURER_ID;
            cfg_reg.model_id           <= sbdp_pkg::RST_MODEL_ID;
            cfg_reg.voice_address_high <= sbdp_pkg::RST_VOICE_ADDRESS_HIGH;
            cfg_reg.min_data_bytes     <= sbdp_pkg::RST_MIN_DATA_BYTES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/sbdp_in_stage.sv @@
// Input register of the bulk-dump message parser.
`default_nettype none

module sbdp_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] byte_in,
    input  wire logic       take,
    output logic            held_valid,
    output logic [7:0]      held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // The register is free when empty or when its item moves on this cycle.
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= byte_in;
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

`default_nettype wire

@@ src/sbdp_parse.sv @@
// Message state and per-byte decode of the bulk-dump message parser.
`default_nettype none

module sbdp_parse (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic [7:0]     byte_cur,
    input  wire sbdp_pkg::cfg_t cfg,
    output logic                res_valid,
    output sbdp_pkg::result_t   res
);

    logic        in_msg_reg,   in_msg_next;
    logic [14:0] position_reg, position_next;
    logic [6:0]  sum_reg,      sum_next;
    logic [13:0] count_reg,    count_next;
    logic [20:0] addr_reg,     addr_next;
    logic        maker_ok_reg, maker_ok_next;
    logic        bulk_ok_reg,  bulk_ok_next;
    logic        model_ok_reg, model_ok_next;

    logic [6:0]         b7;
    logic [14:0]        data_rel;
    logic               data_hit;
    logic [15:0]        expect_end;
    sbdp_pkg::status_t  verdict;

    assign b7         = byte_cur[6:0];
    assign data_rel   = position_reg - sbdp_pkg::POS_DATA_START;
    assign data_hit   = (position_reg >= sbdp_pkg::POS_DATA_START)
                        && (data_rel < {1'b0, count_reg});
    assign expect_end = {1'b0, sbdp_pkg::POS_MIN_END} + {2'b00, count_reg};

    // First failing check decides the verdict.
    always_comb
    begin
        priority if (position_reg < sbdp_pkg::POS_MIN_END)
            verdict = sbdp_pkg::ST_NOT_SYSEX;
        else if (!maker_ok_reg)
            verdict = sbdp_pkg::ST_MANUFACTURER;
        else if (!bulk_ok_reg)
            verdict = sbdp_pkg::ST_NOT_BULK;
        else if (!model_ok_reg)
            verdict = sbdp_pkg::ST_MODEL;
        else if ({1'b0, position_reg} != expect_end)
            verdict = sbdp_pkg::ST_LENGTH;
        else if (sum_reg != 7'd0)
            verdict = sbdp_pkg::ST_CHECKSUM;
        else if (addr_reg[20:14] != cfg.voice_address_high)
            verdict = sbdp_pkg::ST_ADDRESS;
        else if (count_reg < cfg.min_data_bytes)
            verdict = sbdp_pkg::ST_TOO_SHORT;
        else
            verdict = sbdp_pkg::ST_OK;
    end

    always_comb
    begin
        in_msg_next   = in_msg_reg;
        position_next = position_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        addr_next     = addr_reg;
        maker_ok_next = maker_ok_reg;
        bulk_ok_next  = bulk_ok_reg;
        model_ok_next = model_ok_reg;

        res_valid        = 1'b0;
        res.is_verdict   = 1'b0;
        res.data_byte    = 7'd0;
        res.data_index   = 14'd0;
        res.status       = sbdp_pkg::ST_OK;
        res.dump_address = 21'd0;
        res.data_count   = 14'd0;
        res.last         = 1'b0;

        if (step)
        begin
            if (!in_msg_reg)
            begin
                if (byte_cur == sbdp_pkg::MSG_START)
                begin
                    in_msg_next   = 1'b1;
                    position_next = sbdp_pkg::POS_MAKER;
                    sum_next      = 7'd0;
                    count_next    = 14'd0;
                    addr_next     = 21'd0;
                    maker_ok_next = 1'b0;
                    bulk_ok_next  = 1'b0;
                    model_ok_next = 1'b0;
                end
            end
            else if (byte_cur == sbdp_pkg::MSG_END)
            begin
                in_msg_next      = 1'b0;
                res_valid        = 1'b1;
                res.is_verdict   = 1'b1;
                res.status       = verdict;
                res.dump_address = addr_reg;
                res.data_count   = count_reg;
                res.last         = 1'b1;
            end
            else
            begin
                unique case (position_reg)
                    sbdp_pkg::POS_MAKER:    maker_ok_next = (byte_cur == {1'b0, cfg.manufacturer_id});
                    sbdp_pkg::POS_BULK:     bulk_ok_next  = (byte_cur[7:4] == 4'd0);
                    sbdp_pkg::POS_MODEL:    model_ok_next = (byte_cur == {1'b0, cfg.model_id});
                    sbdp_pkg::POS_COUNT_HI: count_next    = {b7, 7'd0};
                    sbdp_pkg::POS_COUNT_LO: count_next    = {count_reg[13:7], b7};
                    sbdp_pkg::POS_ADDR_HI:  addr_next     = {b7, 14'd0};
                    sbdp_pkg::POS_ADDR_MID: addr_next     = {addr_reg[20:14], b7, 7'd0};
                    sbdp_pkg::POS_ADDR_LO:  addr_next     = {addr_reg[20:7], b7};
                    default:                addr_next     = addr_reg;
                endcase

                if (position_reg >= sbdp_pkg::POS_COUNT_HI)
                    sum_next = sum_reg + b7;

                if (position_reg != sbdp_pkg::POS_MAX)
                    position_next = position_reg + 15'd1;

                if (data_hit)
                begin
                    res_valid      = 1'b1;
                    res.data_byte  = b7;
                    res.data_index = data_rel[13:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg   <= 1'b0;
            position_reg <= 15'd0;
            sum_reg      <= 7'd0;
            count_reg    <= 14'd0;
            addr_reg     <= 21'd0;
            maker_ok_reg <= 1'b0;
            bulk_ok_reg  <= 1'b0;
            model_ok_reg <= 1'b0;
        end
        else
        begin
            in_msg_reg   <= in_msg_next;
            position_reg <= position_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            addr_reg     <= addr_next;
            maker_ok_reg <= maker_ok_next;
            bulk_ok_reg  <= bulk_ok_next;
            model_ok_reg <= model_ok_next;
        end
    end

`ifndef ASSERT_OFF
    // Bytes outside a message never produce an item.
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        step && !in_msg_reg |-> !res_valid)
        else $error("item produced outside a message");

    // Inside a message the position has moved past the start byte.
    a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_msg_reg |-> position_reg != 15'd0)
        else $error("message open at position zero");

    // A data item always lies inside the announced data section.
    a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.is_verdict |-> res.data_index < count_reg)
        else $error("data item beyond the byte count");

    // A verdict closes the message.
    a_verdict_closes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.is_verdict |=> !in_msg_reg)
        else $error("message still open after its verdict");
`endif

endmodule

`default_nettype wire

@@ src/sbdp_out_stage.sv @@
// Result register of the bulk-dump message parser.
`default_nettype none

module sbdp_out_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire sbdp_pkg::result_t res,
    output logic                   free,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sbdp_pkg::result_t      out_res
);

    logic              valid_reg;
    logic              valid_next;
    sbdp_pkg::result_t res_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire
